// File: rtl/core/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared types, operation codes and defaults for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned PROD_W            = 2 * DATA_W;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  typedef enum logic [3:0] {
    MODE_ADD     = 4'd0,
    MODE_SUB     = 4'd1,
    MODE_MUL     = 4'd2,
    MODE_DIV     = 4'd3,
    MODE_GT      = 4'd4,
    MODE_LT      = 4'd5,
    MODE_GE      = 4'd6,
    MODE_LE      = 4'd7,
    MODE_EQ      = 4'd8,
    MODE_NE      = 4'd9,
    MODE_MIN     = 4'd10,
    MODE_MAX     = 4'd11,
    MODE_INC     = 4'd12,
    MODE_DEC     = 4'd13,
    MODE_FROMINT = 4'd14,
    MODE_TOINT   = 4'd15
  } mode_e;

  typedef struct packed {
    mode_e                    mode;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     compare_true;
    logic                     divide_by_zero;
  } out_t;

  // Side information that travels alongside the divider datapath.
  typedef struct packed {
    logic                     is_mul;
    logic                     is_div;
    logic                     neg;
    logic                     cmp;
    logic                     dz;
    logic [DATA_W-1:0]        res;
    logic signed [PROD_W-1:0] prod;
  } side_t;

endpackage

// File: rtl/core/fpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU front stage
// Evaluates the simple operations, forms the product and prepares the
// magnitudes for the divider.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
  parameter int unsigned DIV_W         = fpa_pkg::DATA_W + FRACTION_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  fpa_pkg::in_t                data_i,
  output logic                        valid_o,
  output fpa_pkg::side_t              side_o,
  output logic [fpa_pkg::DATA_W-1:0]  rem_o,
  output logic [DIV_W-1:0]            quo_o,
  output logic [fpa_pkg::DATA_W-1:0]  dvsr_o
);
  import fpa_pkg::*;

  logic signed [DATA_W-1:0] a;
  logic signed [DATA_W-1:0] b;
  logic signed [DIV_W-1:0]  a_ext;
  logic signed [DIV_W-1:0]  num;
  logic [DIV_W-1:0]         n_mag;
  logic [DATA_W-1:0]        d_mag;
  side_t                    side_d;
  side_t                    side_q;
  logic                     valid_q;
  logic [DIV_W-1:0]         quo_q;
  logic [DATA_W-1:0]        dvsr_q;

  always_comb begin
    a      = data_i.operand_a;
    b      = data_i.operand_b;
    a_ext  = DIV_W'(a);
    num    = a_ext <<< FRACTION_BITS;
    n_mag  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
    d_mag  = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
    side_d        = '0;
    side_d.prod   = PROD_W'(a) * PROD_W'(b);
    side_d.is_mul = (data_i.mode == MODE_MUL);
    side_d.is_div = (data_i.mode == MODE_DIV);
    side_d.neg    = a[DATA_W-1] ^ b[DATA_W-1];
    case (data_i.mode)
      MODE_ADD:     side_d.res = DATA_W'(a + b);
      MODE_SUB:     side_d.res = DATA_W'(a - b);
      MODE_DIV:     side_d.dz  = (b == '0);
      MODE_GT:      side_d.cmp = (a > b);
      MODE_LT:      side_d.cmp = (a < b);
      MODE_GE:      side_d.cmp = (a >= b);
      MODE_LE:      side_d.cmp = (a <= b);
      MODE_EQ:      side_d.cmp = (a == b);
      MODE_NE:      side_d.cmp = (a != b);
      MODE_MIN:     side_d.res = (a < b) ? a : b;
      MODE_MAX:     side_d.res = (a > b) ? a : b;
      MODE_INC:     side_d.res = DATA_W'(a + DATA_W'(1));
      MODE_DEC:     side_d.res = DATA_W'(a - DATA_W'(1));
      MODE_FROMINT: side_d.res = DATA_W'(a <<< FRACTION_BITS);
      MODE_TOINT:   side_d.res = DATA_W'(a >>> FRACTION_BITS);
      default:      side_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      quo_q  <= n_mag;
      dvsr_q <= d_mag;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = '0;
  assign quo_o   = quo_q;
  assign dvsr_o  = dvsr_q;

endmodule

// File: rtl/core/fpa_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU divider step
// One registered restoring division step, producing one quotient bit.
// ----------------------------------------------------------------------------
module fpa_div_step #(
  parameter int unsigned DIV_W = fpa_pkg::DATA_W + fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  fpa_pkg::side_t              side_i,
  input  logic [fpa_pkg::DATA_W-1:0]  rem_i,
  input  logic [DIV_W-1:0]            quo_i,
  input  logic [fpa_pkg::DATA_W-1:0]  dvsr_i,
  output logic                        valid_o,
  output fpa_pkg::side_t              side_o,
  output logic [fpa_pkg::DATA_W-1:0]  rem_o,
  output logic [DIV_W-1:0]            quo_o,
  output logic [fpa_pkg::DATA_W-1:0]  dvsr_o
);
  import fpa_pkg::*;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] trial;
  logic              ge;
  logic [DATA_W-1:0] rem_d;
  logic [DIV_W-1:0]  quo_d;
  logic              valid_q;
  side_t             side_q;
  logic [DATA_W-1:0] rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DATA_W-1:0] dvsr_q;

  always_comb begin
    shifted = {rem_i, quo_i[DIV_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr_i};
    ge      = !trial[DATA_W+1];
    rem_d   = ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
    quo_d   = {quo_i[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvsr_q <= dvsr_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign dvsr_o  = dvsr_q;

endmodule

// File: rtl/core/fpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU back stage
// Applies the quotient sign, scales the product and registers the result.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
  parameter int unsigned DIV_W         = fpa_pkg::DATA_W + FRACTION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fpa_pkg::side_t   side_i,
  input  logic [DIV_W-1:0] quo_i,
  output logic             valid_o,
  output fpa_pkg::out_t    data_o
);
  import fpa_pkg::*;

  logic [DIV_W-1:0] quo_s;
  out_t             data_d;
  out_t             data_q;
  logic             valid_q;

  always_comb begin
    quo_s  = side_i.neg ? DIV_W'(-quo_i) : quo_i;
    data_d = '0;
    data_d.compare_true   = side_i.cmp;
    data_d.divide_by_zero = side_i.dz;
    if (side_i.is_mul) begin
      data_d.result_value = side_i.prod[FRACTION_BITS +: DATA_W];
    end else if (side_i.is_div) begin
      data_d.result_value = side_i.dz ? '0 : quo_s[DATA_W-1:0];
    end else begin
      data_d.result_value = side_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/core/fixed_point_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Pipelined signed 32-bit fixed-point ALU with a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Usage: present an opcode and two raw operands on in_data_i with in_valid_i;
// a transfer takes place when in_valid_i and in_ready_o are both high. Each
// input transfer yields exactly one result transfer on out_data_o, in order.
// Every operation travels the same pipeline: an input register, a front
// stage, one divider stage per quotient bit (32 + FRACTION_BITS of them) and
// an output register, whatever its opcode. A new operation is accepted in
// every cycle in which the pipeline is not frozen, so throughput is one
// transfer per cycle while the receiver takes results. When the receiver
// holds out_ready_i low with a result pending, the whole pipeline freezes
// and in_ready_o falls; nothing is dropped or repeated. Reset clears all
// valid bits, leaving the pipeline empty.
// ----------------------------------------------------------------------------
module fixed_point_alu_top #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::out_t out_data_o
);
  import fpa_pkg::*;

  localparam int unsigned DIV_W = DATA_W + FRACTION_BITS;

  logic              en;
  logic              in_valid_q;
  in_t               in_data_q;
  logic              valid_s [DIV_W+1];
  side_t             side_s  [DIV_W+1];
  logic [DATA_W-1:0] rem_s   [DIV_W+1];
  logic [DIV_W-1:0]  quo_s   [DIV_W+1];
  logic [DATA_W-1:0] dvsr_s  [DIV_W+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_data_q <= in_data_i;
    end
  end

  fpa_front #(
    .FRACTION_BITS(FRACTION_BITS),
    .DIV_W        (DIV_W)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_q),
    .data_i (in_data_q),
    .valid_o(valid_s[0]),
    .side_o (side_s[0]),
    .rem_o  (rem_s[0]),
    .quo_o  (quo_s[0]),
    .dvsr_o (dvsr_s[0])
  );

  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    fpa_div_step #(
      .DIV_W(DIV_W)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_s[i]),
      .side_i (side_s[i]),
      .rem_i  (rem_s[i]),
      .quo_i  (quo_s[i]),
      .dvsr_i (dvsr_s[i]),
      .valid_o(valid_s[i+1]),
      .side_o (side_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .quo_o  (quo_s[i+1]),
      .dvsr_o (dvsr_s[i+1])
    );
  end

  fpa_back #(
    .FRACTION_BITS(FRACTION_BITS),
    .DIV_W        (DIV_W)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(valid_s[DIV_W]),
    .side_i (side_s[DIV_W]),
    .quo_i  (quo_s[DIV_W]),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

  // A divide by zero always reports a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |-> out_data_o.result_value == '0)
    else $error("divide by zero with non-zero result");

  // A compare outcome always comes with a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.compare_true |-> out_data_o.result_value == '0)
    else $error("compare outcome with non-zero result");

  // A result cannot be both a compare outcome and a divide by zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.compare_true && out_data_o.divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

endmodule

// File: dv/tb_fixed_point_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives opcode and operand transfers into the ALU through a bursty sender,
// stalls the result side on its own pattern, and checks every result against
// a behavioural fixed-point predictor, in order and field by field.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_top;
  import fpa_pkg::*;

  localparam int unsigned FRAC      = FRACTION_BITS_DEF;
  localparam int unsigned LATENCY   = FRAC + 35;
  localparam int          N_RANDOM  = 1650;
  localparam int          WDOG_MAX  = 20000;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  out_t  out_data;

  in_t   pending_ops[$];
  out_t  expected_results[$];
  int    mismatches;
  int    idle_cycles;
  bit    stimulus_done;
  bit    hold_sender;
  bit    in_fire;
  int    burst_left;
  int    gap_left;
  int    stall_phase;

  fixed_point_alu_top #(.FRACTION_BITS(FRAC)) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  function automatic out_t alu_compute(in_t op);
    out_t r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] wide;
    a = op.operand_a;
    b = op.operand_b;
    r = '0;
    case (op.mode)
      MODE_ADD:     r.result_value = op.operand_a + op.operand_b;
      MODE_SUB:     r.result_value = op.operand_a - op.operand_b;
      MODE_MUL: begin
        wide = (a * b) >>> FRAC;
        r.result_value = wide[31:0];
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          wide = (a <<< FRAC) / b;
          r.result_value = wide[31:0];
        end
      end
      MODE_GT:      r.compare_true = a > b;
      MODE_LT:      r.compare_true = a < b;
      MODE_GE:      r.compare_true = a >= b;
      MODE_LE:      r.compare_true = a <= b;
      MODE_EQ:      r.compare_true = a == b;
      MODE_NE:      r.compare_true = a != b;
      MODE_MIN:     r.result_value = (a < b) ? op.operand_a : op.operand_b;
      MODE_MAX:     r.result_value = (a > b) ? op.operand_a : op.operand_b;
      MODE_INC:     r.result_value = op.operand_a + 32'sd1;
      MODE_DEC:     r.result_value = op.operand_a - 32'sd1;
      MODE_FROMINT: r.result_value = op.operand_a <<< FRAC;
      default:      r.result_value = op.operand_a >>> FRAC;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 1024)) - 512);
      4: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
      5: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(mode_e m, logic [31:0] a, logic [31:0] b);
    in_t op;
    op.mode      = m;
    op.operand_a = a;
    op.operand_b = b;
    pending_ops.push_back(op);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    logic [31:0] x;
    rst_n = 1'b0;
    stimulus_done = 1'b0;
    hold_sender = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int m = 0; m < 16; m++) begin
      queue_op(mode_e'(m), 32'h7FFF_FFFF, 32'h8000_0000);
    end
    queue_op(MODE_DIV, 32'h0000_0300, 32'h0);
    queue_op(MODE_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    queue_op(MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(MODE_MIN, 32'h0000_1234, 32'h0000_1234);
    queue_op(MODE_MAX, 32'hFFFF_FF00, 32'hFFFF_FF00);
    queue_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_op(MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_op(MODE_INC, 32'h7FFF_FFFF, 32'h0);
    queue_op(MODE_DEC, 32'h8000_0000, 32'hFFFF_FFFF);

    for (int i = 0; i < N_RANDOM; i++) begin
      x = pick_operand();
      queue_op(mode_e'($urandom_range(0, 15)), x,
               ($urandom_range(0, 7) == 0) ? x : pick_operand());
      if (i == N_RANDOM / 2) begin
        wait (pending_ops.size() == 0 && !in_valid);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0);
        @(negedge clk);
        hold_sender = 1'b0;
      end
    end
    wait (pending_ops.size() == 0 && !in_valid);
    stimulus_done = 1'b1;
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
  end

  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0 && !hold_sender) begin
        in_valid <= 1'b1;
        in_data  <= pending_ops.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 9) > stall_phase[9:8] * 2);
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      mismatches  <= 0;
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(alu_compute(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("Unexpected result transfer: %p", out_data);
          end
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.result_value !== out_data.result_value ||
              exp_r.compare_true !== out_data.compare_true ||
              exp_r.divide_by_zero !== out_data.divide_by_zero) begin
            if (mismatches < 10) begin
              $display("Mismatch: expected value %h cmp %b dz %b, got %h cmp %b dz %b",
                       exp_r.result_value, exp_r.compare_true, exp_r.divide_by_zero,
                       out_data.result_value, out_data.compare_true,
                       out_data.divide_by_zero);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    fork
      begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WDOG_MAX);
      end
    join_any
    disable fork;
    if (idle_cycles < WDOG_MAX && mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
